// File: src/upd_pkg.sv
// shared types, character codes and hex helpers for the url percent decoder
// no dependencies
package upd_pkg;

  localparam int ByteW = 8;
  localparam int MaxResults = 3;

  localparam logic [ByteW-1:0] ChPlus    = 8'h2B;
  localparam logic [ByteW-1:0] ChPercent = 8'h25;
  localparam logic [ByteW-1:0] ChSpace   = 8'h20;

  // held escape state
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_PCT   = 2'd1,
    PEND_DIGIT = 2'd2,
    PEND_BAD   = 2'd3
  } pend_t;

  // one raw input word
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } in_word_t;

  // one decoded result word
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             ok;
  } result_t;

  // everything one input word produces
  typedef struct packed {
    logic [1:0]                  count;
    result_t [MaxResults-1:0]    res;
  } bundle_t;

  function automatic logic is_hex(input logic [ByteW-1:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] v;
    v = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h57;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

// File: src/upd_in_stage.sv
// input register for the url percent decoder
// depends on upd_pkg
module upd_in_stage
  import upd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  input  logic             fire,
  output logic             held_valid,
  output in_word_t         held_word
);

  in_word_t word_q;
  logic     valid_q;

  assign in_ready   = !valid_q || fire;
  assign held_valid = valid_q;
  assign held_word  = word_q;

  // load a new word or empty once decoded
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_q <= 1'b1;
    end else if (fire) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_q <= in_word;
    end
  end

endmodule

// File: src/upd_decode.sv
// escape state and single-pass decode of one raw word into up to three results
// depends on upd_pkg
module upd_decode
  import upd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  in_word_t word,
  output bundle_t  bundle
);

  pend_t            pend;
  pend_t            pend_next;
  logic [ByteW-1:0] held;
  logic [ByteW-1:0] held_next;
  logic             all_valid;
  logic             all_valid_next;
  logic [1:0]       n;
  logic [ByteW-1:0] c;
  logic [ByteW-1:0] plain_byte;
  logic             plain_emit;
  logic             plain_pct;

  assign c = word.data;

  // decode of a byte with nothing held
  always_comb begin
    plain_emit = 1'b1;
    plain_pct  = 1'b0;
    plain_byte = c;
    if (c == ChPlus) begin
      plain_byte = ChSpace;
    end else if (c == ChPercent) begin
      plain_emit = 1'b0;
      plain_pct  = 1'b1;
    end
  end

  // main decode
  always_comb begin
    bundle         = '0;
    n              = 2'd0;
    pend_next      = PEND_NONE;
    held_next      = held;
    all_valid_next = all_valid;
    case (pend)
      PEND_PCT: begin
        if (c == ChPercent) begin
          bundle.res[n].data = ChPercent;
          n = n + 2'd1;
        end else if (is_hex(c)) begin
          held_next = c;
          pend_next = PEND_DIGIT;
        end else begin
          bundle.res[n].data = ChPercent;
          n = n + 2'd1;
          all_valid_next = 1'b0;
          if (plain_emit) begin
            bundle.res[n].data = plain_byte;
            n = n + 2'd1;
          end
          if (plain_pct) begin
            pend_next = PEND_PCT;
          end
        end
      end
      PEND_DIGIT: begin
        if (is_hex(c) && is_hex(held)) begin
          bundle.res[n].data = {hex_val(held), hex_val(c)};
          n = n + 2'd1;
        end else begin
          bundle.res[n].data = ChPercent;
          n = n + 2'd1;
          all_valid_next = 1'b0;
          bundle.res[n].data = held;
          n = n + 2'd1;
          if (plain_emit) begin
            bundle.res[n].data = plain_byte;
            n = n + 2'd1;
          end
          if (plain_pct) begin
            pend_next = PEND_PCT;
          end
        end
      end
      default: begin
        if (plain_emit) begin
          bundle.res[n].data = plain_byte;
          n = n + 2'd1;
        end
        if (plain_pct) begin
          pend_next = PEND_PCT;
        end
      end
    endcase

    // end of string: flush what is held, mark the final result
    if (word.last) begin
      if (pend_next == PEND_PCT) begin
        bundle.res[n].data = ChPercent;
        n = n + 2'd1;
        all_valid_next = 1'b0;
      end else if (pend_next == PEND_DIGIT) begin
        bundle.res[n].data = ChPercent;
        n = n + 2'd1;
        all_valid_next = 1'b0;
        bundle.res[n].data = held_next;
        n = n + 2'd1;
      end
      if (n != 2'd0) begin
        bundle.res[n - 2'd1].last = 1'b1;
        bundle.res[n - 2'd1].ok   = all_valid_next;
      end
      pend_next      = PEND_NONE;
      held_next      = '0;
      all_valid_next = 1'b1;
    end
    bundle.count = n;
  end

  // escape state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= PEND_NONE;
      held      <= '0;
      all_valid <= 1'b1;
    end else if (fire) begin
      pend      <= pend_next;
      held      <= held_next;
      all_valid <= all_valid_next;
    end
  end

endmodule

// File: src/upd_out_queue.sv
// four-entry shifting result queue, takes up to three words per cycle while it has room
// depends on upd_pkg
module upd_out_queue
  import upd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t bundle,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_word
);

  localparam int Depth = MaxResults + 1;

  result_t    q [Depth];
  result_t    q_next [Depth];
  logic [2:0] count;
  logic [2:0] base;
  logic [2:0] count_next;
  logic       pop;
  logic [2:0] rel;

  assign out_valid = (count != 3'd0);
  assign out_word  = q[0];
  assign pop       = out_valid && out_ready;
  assign base      = count - {2'b00, pop};
  // at most one word left after this cycle's pop leaves room for three
  assign room      = (base <= 3'd1);

  // shift out the taken word, append the new results behind the rest
  always_comb begin
    rel = '0;
    for (int i = 0; i < Depth; i++) begin
      if (pop && (i < Depth - 1)) begin
        q_next[i] = q[i + 1];
      end else begin
        q_next[i] = q[i];
      end
      rel = 3'(i) - base;
      if (push && (3'(i) >= base) && (rel < {1'b0, bundle.count})) begin
        q_next[i] = bundle.res[rel[1:0]];
      end
    end
    count_next = base + (push ? {1'b0, bundle.count} : 3'd0);
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < Depth; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule

// File: src/url_percent_decoder.sv
// url form decoder top level: input register, decode, result queue
// depends on upd_pkg, upd_in_stage, upd_decode, upd_out_queue
//
//  channel | direction | handshake              | payload
//  s_*     | in        | s_tvalid / s_tready    | tdata = raw byte, tlast = final byte
//  m_*     | out       | m_tvalid / m_tready    | tdata = decoded byte, tlast, tuser = ok
//
// one raw word is taken per cycle while the input register can take it; it is
// decoded from the input register and its results are registered into the
// queue once the queue has room.
// a word yielding three results holds back the next word; a word is
// decoded only once at most one result is left queued after this cycle's pop.
// rst is synchronous and clears the escape state and both registers.
module url_percent_decoder
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,
  output logic [0:0] m_tuser    // [0] decode_ok
);

  in_word_t in_word;
  in_word_t held_word;
  logic     held_valid;
  logic     room;
  logic     fire;
  bundle_t  bundle;
  result_t  out_word;

  assign in_word.data = s_tdata;
  assign in_word.last = s_tlast;
  assign fire         = held_valid && room;

  // input register
  upd_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_word   (in_word),
    .fire      (fire),
    .held_valid(held_valid),
    .held_word (held_word)
  );

  // decode
  upd_decode u_dec (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .word  (held_word),
    .bundle(bundle)
  );

  // result queue
  upd_out_queue u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (fire),
    .bundle   (bundle),
    .room     (room),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_word (out_word)
  );

  assign m_tdata    = out_word.data;
  assign m_tlast    = out_word.last;
  assign m_tuser[0] = out_word.ok;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for url_percent_decoder: streams encoded strings in,
// predicts the decoded words and compares every result field by field
// depends on upd_pkg and the url_percent_decoder rtl
module testbench
  import upd_pkg::*;
;

  // predictor and store of expected decoded words
  class decode_scoreboard;
    result_t expected_q[$];
    result_t step_q[$];
    pend_t   pend;
    logic [7:0] held;
    bit      all_ok;
    int      failures;
    int      words_in;
    int      words_out;
    int      strings;
    int      bad_strings;

    function new();
      pend   = PEND_NONE;
      held   = 8'h00;
      all_ok = 1'b1;
    endfunction

    function int digit_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      return -1;
    endfunction

    function void put(logic [7:0] b);
      result_t w;
      w.data = b;
      w.last = 1'b0;
      w.ok   = 1'b0;
      if (step_q.size() < MaxResults) step_q.insert(step_q.size(), w);
    endfunction

    // a byte seen with nothing held back
    function void take_plain(logic [7:0] c);
      if (c == ChPlus) put(ChSpace);
      else if (c == ChPercent) pend = PEND_PCT;
      else put(c);
    endfunction

    // work out the words one accepted input word causes
    function void note_word(logic [7:0] c, logic fin);
      pend_t was;
      int lo;
      int hi;
      int idx;
      was = pend;
      pend = PEND_NONE;
      step_q.delete();
      words_in++;
      case (was)
        PEND_PCT: begin
          if (c == ChPercent) begin
            put(ChPercent);
          end else if (digit_of(c) >= 0) begin
            held = c;
            pend = PEND_DIGIT;
          end else begin
            put(ChPercent);
            all_ok = 1'b0;
            take_plain(c);
          end
        end
        PEND_DIGIT: begin
          lo = digit_of(c);
          hi = digit_of(held);
          if (lo >= 0 && hi >= 0) begin
            put(8'(hi * 16 + lo));
          end else begin
            put(ChPercent);
            all_ok = 1'b0;
            put(held);
            take_plain(c);
          end
        end
        default: take_plain(c);
      endcase
      if (fin) begin
        // escape cut off by the end of the string goes out literally
        if (pend == PEND_PCT) begin
          put(ChPercent);
          all_ok = 1'b0;
        end else if (pend == PEND_DIGIT) begin
          put(ChPercent);
          all_ok = 1'b0;
          put(held);
        end
        if (step_q.size() > 0) begin
          idx = step_q.size() - 1;
          step_q[idx].last = 1'b1;
          step_q[idx].ok   = all_ok;
        end
        strings++;
        if (!all_ok) bad_strings++;
        pend   = PEND_NONE;
        held   = 8'h00;
        all_ok = 1'b1;
      end
      foreach (step_q[i]) expected_q.insert(expected_q.size(), step_q[i]);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_word(logic [7:0] data, logic last, logic ok);
      result_t want;
      words_out++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected word: data %02h last %b ok %b", data, last, ok);
        return;
      end
      want = expected_q.pop_front();
      if (want.data !== data || want.last !== last || want.ok !== ok) begin
        failures++;
        if (failures <= 10)
          $display("word %0d wrong: expected data %02h last %b ok %b, got %02h %b %b",
                   words_out, want.data, want.last, want.ok, data, last, ok);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [0:0] m_tuser;

  decode_scoreboard sb = new();
  logic [7:0] text_q[$];
  bit  src_idle_on;
  bit  sink_idle_on;
  int  sink_hold;
  int  sink_gap;
  int  in_stalls;

  url_percent_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: any requested hold-off first, then random stall bursts while enabled
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else if (sink_gap > 0) begin
      m_tready <= 1'b0;
      sink_gap = sink_gap - 1;
    end else begin
      m_tready <= 1'b1;
      if (sink_idle_on && $urandom_range(0, 4) == 0) sink_gap = $urandom_range(1, 5);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast, m_tuser[0]);
      if (s_tvalid && !s_tready) in_stalls++;
    end
  end

  // append one raw byte to the string being built
  function automatic void add_char(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  // offer one word and hold it until taken
  task automatic send_word(input logic [7:0] b, input logic fin);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    sb.note_word(b, fin);
  endtask

  // sender drops valid and idles, with junk on the data lines; n sets the length
  task automatic src_gap(input int n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tdata  <= 8'($urandom);
    s_tlast  <= 1'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_string();
    for (int i = 0; i < text_q.size(); i++) begin
      send_word(text_q[i], i == text_q.size() - 1);
      if (src_idle_on && $urandom_range(0, 3) == 0) src_gap($urandom_range(1, 5));
    end
  endtask

  task automatic send_text(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    send_string();
  endtask

  // sender stops until every expected word has come back
  task automatic drain();
    src_gap(1);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'(48 + v);
    return 8'(($urandom_range(0, 1) != 0 ? 97 : 65) + v - 10);
  endfunction

  // random tokens: plain bytes, plus signs, well-formed escapes, some broken, some noise
  task automatic build_random_text();
    int ntok;
    int roll;
    text_q.delete();
    ntok = $urandom_range(1, 6);
    repeat (ntok) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        add_char(8'($urandom_range(32, 126)));
      end else if (roll < 40) begin
        add_char(ChPlus);
      end else if (roll < 48) begin
        add_char(ChPercent);
        add_char(ChPercent);
      end else if (roll < 78) begin
        add_char(ChPercent);
        add_char(hex_char($urandom_range(0, 15)));
        add_char(hex_char($urandom_range(0, 15)));
      end else if (roll < 84) begin
        add_char(ChPercent);
        add_char(8'($urandom));
      end else if (roll < 90) begin
        add_char(ChPercent);
        add_char(hex_char($urandom_range(0, 15)));
        add_char(8'($urandom));
      end else if (roll < 94) begin
        add_char(ChPercent);
      end else begin
        add_char(8'($urandom));
      end
    end
  endtask

  // run limit
  initial begin
    #1_600_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // stimulus
  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = 8'h00;
    s_tlast      = 1'b0;
    m_tready     = 1'b0;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    sink_hold    = 0;
    sink_gap     = 0;
    in_stalls    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: plus, double percent, hex of both cases, broken and cut-off escapes
    send_text("a+%%");
    send_text("%fF");
    send_text("%00");
    send_text("%7E");
    send_text("%+x");
    send_text("%4%");
    send_text("%");
    send_text("%A");
    send_text("%%%");
    text_q = '{8'h00, 8'hFF};
    send_string();
    drain();

    // receiver holds off while the sender keeps going, so the queue backs up
    src_idle_on = 1'b0;
    sink_hold   = 80;
    send_text("%4%%4+%zz");
    send_text("%9g+ab%%");
    repeat (4) begin
      build_random_text();
      send_string();
    end
    drain();

    // random strings with idling on both sides
    src_idle_on = 1'b1;
    while (sb.words_in < 260) begin
      build_random_text();
      send_string();
      if ($urandom_range(0, 2) == 0) src_gap($urandom_range(1, 5));
    end

    // closing stretch at full rate
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    while (sb.words_in < 330) begin
      build_random_text();
      send_string();
    end
    drain();
    repeat (10) @(posedge clk);

    sb.failures += sb.expected_q.size();
    $display("covered %0d strings (%0d with bad escapes), %0d words in, %0d words out",
             sb.strings, sb.bad_strings, sb.words_in, sb.words_out);
    $display("input held off for %0d cycles in total", in_stalls);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
